@@ sv/tfr_pkg.sv @@
package tfr_pkg;

  // Payload bytes held for PID triples (three triples of three int16 words)
  localparam int STORE_BYTES = 18;
  localparam int IDX_W       = $clog2(STORE_BYTES);

  // Job queue between parser and sequencer
  localparam int QUEUE_DEPTH = 2;

  // Frame framing and function codes
  localparam logic [7:0] SOF_1       = 8'hAA;
  localparam logic [7:0] SOF_2       = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
  localparam logic [7:0] FUNC_REQ    = 8'h02;
  localparam logic [7:0] FUNC_PID3   = 8'h10;
  localparam logic [7:0] FUNC_PID1   = 8'h11;
  localparam logic [7:0] FUNC_ACK_LO = 8'h12;
  localparam logic [7:0] FUNC_ACK_HI = 8'h15;
  localparam logic [7:0] SUB_READ    = 8'h01;
  localparam logic [7:0] SUB_DEFAULT = 8'hA1;

  // Acknowledge frame: SOF_1 SOF_1 ACK_ADDR ACK_FUNC func sum chk
  localparam logic [7:0] ACK_ADDR = 8'hEF;
  localparam logic [7:0] ACK_FUNC = 8'h02;
  localparam logic [7:0] ACK_BASE = 8'(SOF_1 + SOF_1 + ACK_ADDR + ACK_FUNC);
  localparam int         ACK_LEN  = 7;

  localparam int STEP_W = 4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SOF2,
    PH_FUNC,
    PH_LEN,
    PH_DATA,
    PH_CHK
  } phase_e;

  typedef enum logic [1:0] {
    KIND_ACK,
    KIND_PID,
    KIND_READ,
    KIND_DEFAULT
  } kind_e;

  typedef enum logic [2:0] {
    OP_READ,
    OP_DEFAULT,
    OP_PID3,
    OP_PID1,
    OP_ACK
  } op_e;

  typedef struct packed {
    op_e                         op;
    logic [7:0]                  func;
    logic [7:0]                  sum;
    logic [STORE_BYTES-1:0][7:0] data;
  } job_t;

  // Number of result items a job produces
  function automatic logic [STEP_W-1:0] op_steps(op_e op);
    logic [STEP_W-1:0] n;
    case (op)
      OP_READ:    n = STEP_W'(1);
      OP_DEFAULT: n = STEP_W'(1);
      OP_PID3:    n = STEP_W'(3 + ACK_LEN);
      OP_PID1:    n = STEP_W'(1 + ACK_LEN);
      OP_ACK:     n = STEP_W'(ACK_LEN);
      default:    n = STEP_W'(1);
    endcase
    return n;
  endfunction

  // Number of PID triples ahead of the acknowledge
  function automatic logic [STEP_W-1:0] op_triples(op_e op);
    logic [STEP_W-1:0] n;
    case (op)
      OP_PID3: n = STEP_W'(3);
      OP_PID1: n = STEP_W'(1);
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

@@ sv/tfr_parser.sv @@
module tfr_parser import tfr_pkg::*; #(
  parameter int MAX_PAYLOAD_LEN = 49
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output job_t       job_o
);

  localparam int         LEN_W   = $clog2(MAX_PAYLOAD_LEN + 1);
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD_LEN);

  phase_e                      phase_q, phase_d;
  logic [7:0]                  func_q, func_d;
  logic [LEN_W-1:0]            rem_q, rem_d;
  logic [LEN_W-1:0]            cnt_q, cnt_d;
  logic [7:0]                  sum_q, sum_d;
  logic [STORE_BYTES-1:0][7:0] store_q;
  logic [STORE_BYTES-1:0][7:0] snap;
  logic                        accept;
  logic                        store_we;
  logic                        sum_ok;
  logic                        op_hit;
  op_e                         op;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  // payload bytes and the checksum byte land in the store while the count is below
  // STORE_BYTES; not the byte that drops a zero-length frame
  assign store_we   = accept
                      && ((phase_q == PH_DATA && rem_q != '0) || phase_q == PH_CHK)
                      && (cnt_q < LEN_W'(STORE_BYTES));

  // Store image with this byte written at the current count
  always_comb begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      snap[i] = (cnt_q == LEN_W'(i)) ? rx_byte_i : store_q[i];
    end
  end

  // Classify a completed frame
  always_comb begin
    op     = OP_ACK;
    op_hit = 1'b0;
    if (func_q == FUNC_REQ) begin
      if (snap[0] == SUB_READ) begin
        op     = OP_READ;
        op_hit = 1'b1;
      end else if (snap[0] == SUB_DEFAULT) begin
        op     = OP_DEFAULT;
        op_hit = 1'b1;
      end
    end else if (func_q == FUNC_PID3) begin
      op     = OP_PID3;
      op_hit = 1'b1;
    end else if (func_q == FUNC_PID1) begin
      op     = OP_PID1;
      op_hit = 1'b1;
    end else if (func_q inside {[FUNC_ACK_LO:FUNC_ACK_HI]}) begin
      op     = OP_ACK;
      op_hit = 1'b1;
    end
  end

  assign sum_ok     = (rx_byte_i == sum_q);
  assign push_o     = accept && (phase_q == PH_CHK) && sum_ok && op_hit;
  assign job_o.op   = op;
  assign job_o.func = func_q;
  assign job_o.sum  = sum_q;
  assign job_o.data = snap;

  // Frame parser next state
  always_comb begin
    phase_d = phase_q;
    func_d  = func_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    if (accept) begin
      case (phase_q)
        PH_IDLE: begin
          if (rx_byte_i == SOF_1) begin
            phase_d = PH_SOF2;
            sum_d   = rx_byte_i;
          end
        end
        PH_SOF2: begin
          phase_d = PH_IDLE;
          if (rx_byte_i == SOF_2) begin
            phase_d = PH_FUNC;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        PH_FUNC: begin
          phase_d = PH_IDLE;
          if (rx_byte_i < FUNC_LIMIT) begin
            phase_d = PH_LEN;
            func_d  = rx_byte_i;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        PH_LEN: begin
          phase_d = PH_IDLE;
          if (rx_byte_i <= MAX_LEN) begin
            phase_d = PH_DATA;
            rem_d   = rx_byte_i[LEN_W-1:0];
            cnt_d   = '0;
            sum_d   = sum_q + rx_byte_i;
          end
        end
        PH_DATA: begin
          // zero-length frame: the byte after the length drops the frame
          phase_d = PH_IDLE;
          if (rem_q != '0) begin
            phase_d = (rem_q == LEN_W'(1)) ? PH_CHK : PH_DATA;
            rem_d   = rem_q - LEN_W'(1);
            cnt_d   = cnt_q + LEN_W'(1);
            sum_d   = sum_q + rx_byte_i;
          end
        end
        PH_CHK: begin
          phase_d = PH_IDLE;
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      func_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      func_q  <= func_d;
      rem_q   <= rem_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  // Payload store, stale bytes read as zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
    end else if (store_we) begin
      store_q[cnt_q[IDX_W-1:0]] <= rx_byte_i;
    end
  end

  a_push_from_chk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> phase_q == PH_CHK && cnt_q != '0)
    else $error("job pushed outside checksum phase");

  a_chk_follows_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CHK |-> rem_q == '0 && cnt_q != '0)
    else $error("checksum phase with payload outstanding");

endmodule

@@ sv/tfr_queue.sv @@
module tfr_queue import tfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = entry_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

  // Job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");

endmodule

@@ sv/tfr_seq.sv @@
module tfr_seq import tfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         tx_byte_o,
  output logic [1:0]         wheel_o,
  output logic signed [15:0] kp_o,
  output logic signed [15:0] ki_o,
  output logic signed [15:0] kd_o,
  output logic               last_o
);

  logic [STEP_W-1:0] step_q, step_d;
  logic [STEP_W-1:0] total;
  logic [STEP_W-1:0] ntrip;
  logic [2:0]        ack_idx;
  logic [1:0]        trip;
  logic              load;
  logic              is_last;
  logic              is_trip;
  logic [47:0]       gains;
  logic [7:0]        ack_byte;

  logic              valid_q;
  kind_e             kind_q, kind_d;
  logic [7:0]        tx_q, tx_d;
  logic [1:0]        wheel_q, wheel_d;
  logic [47:0]       gains_q, gains_d;
  logic              last_q;

  assign total   = op_steps(job_i.op);
  assign ntrip   = op_triples(job_i.op);
  assign is_last = (step_q == total - STEP_W'(1));
  assign is_trip = (step_q < ntrip);
  assign trip    = step_q[1:0];
  assign ack_idx = 3'(step_q - ntrip);
  assign load    = job_valid_i && (!valid_q || !out_stall_i);
  assign pop_o   = load && is_last;

  // Select the three big-endian words of one triple
  always_comb begin
    case (trip)
      2'd0:    gains = {job_i.data[0],  job_i.data[1],  job_i.data[2],
                        job_i.data[3],  job_i.data[4],  job_i.data[5]};
      2'd1:    gains = {job_i.data[6],  job_i.data[7],  job_i.data[8],
                        job_i.data[9],  job_i.data[10], job_i.data[11]};
      2'd2:    gains = {job_i.data[12], job_i.data[13], job_i.data[14],
                        job_i.data[15], job_i.data[16], job_i.data[17]};
      default: gains = '0;
    endcase
  end

  // Acknowledge frame bytes
  always_comb begin
    case (ack_idx)
      3'd0:    ack_byte = SOF_1;
      3'd1:    ack_byte = SOF_1;
      3'd2:    ack_byte = ACK_ADDR;
      3'd3:    ack_byte = ACK_FUNC;
      3'd4:    ack_byte = job_i.func;
      3'd5:    ack_byte = job_i.sum;
      3'd6:    ack_byte = ACK_BASE + job_i.func + job_i.sum;
      default: ack_byte = '0;
    endcase
  end

  // Build the next result item
  always_comb begin
    kind_d  = KIND_ACK;
    tx_d    = '0;
    wheel_d = '0;
    gains_d = '0;
    step_d  = step_q;
    case (job_i.op)
      OP_READ:    kind_d = KIND_READ;
      OP_DEFAULT: kind_d = KIND_DEFAULT;
      default: begin
        if (is_trip) begin
          kind_d  = KIND_PID;
          wheel_d = (job_i.op == OP_PID1) ? 2'd3 : trip;
          gains_d = gains;
        end else begin
          tx_d = ack_byte;
        end
      end
    endcase
    if (load) begin
      step_d = is_last ? '0 : step_q + STEP_W'(1);
    end
  end

  // Step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q  <= kind_d;
      tx_q    <= tx_d;
      wheel_q <= wheel_d;
      gains_q <= gains_d;
      last_q  <= is_last;
    end
  end

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign tx_byte_o   = tx_q;
  assign wheel_o     = wheel_q;
  assign kp_o        = gains_q[47:32];
  assign ki_o        = gains_q[31:16];
  assign kd_o        = gains_q[15:0];
  assign last_o      = last_q;

  a_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != '0 |-> job_valid_i)
    else $error("job left the queue mid-sequence");

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> step_q < total)
    else $error("step beyond job length");

endmodule

@@ sv/telemetry_frame_receiver_core.sv @@
// Channel   Handshake                     Payload
// in        in_valid_i / in_stall_o       rx_byte_i
// out       out_valid_o / out_stall_i     kind_o tx_byte_o wheel_o kp_o ki_o kd_o last_o
//
// One byte is taken per cycle while in_stall_o is low; a good frame of a known
// function queues one job, which the sequencer turns into 1 to 10 result items
// at one per cycle while out_stall_i is low. in_stall_o rises only while the
// two-entry job queue is full. Results pass the job queue, then the output register.
// rst_ni clears the parser, the payload store, the queue and the output valid.
module telemetry_frame_receiver_core import tfr_pkg::*; #(
  parameter int MAX_PAYLOAD_LEN = 49
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         kind_o,
  output logic [7:0]         tx_byte_o,
  output logic [1:0]         wheel_o,
  output logic signed [15:0] kp_o,
  output logic signed [15:0] ki_o,
  output logic signed [15:0] kd_o,
  output logic               last_o
);

  logic push;
  logic q_full;
  logic q_valid;
  logic pop;
  job_t push_job;
  job_t head_job;

  // Front: frame parser
  tfr_parser #(
    .MAX_PAYLOAD_LEN(MAX_PAYLOAD_LEN)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Job queue
  tfr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (head_job)
  );

  // Back: result sequencer
  tfr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .tx_byte_o   (tx_byte_o),
    .wheel_o     (wheel_o),
    .kp_o        (kp_o),
    .ki_o        (ki_o),
    .kd_o        (kd_o),
    .last_o      (last_o)
  );

endmodule

@@ verif/testbench.sv @@
module testbench;
  import tfr_pkg::*;

  localparam int MAX_LEN      = 49;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_BYTES = 60;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 200000;

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         tx;
    logic [1:0]         wheel;
    logic signed [15:0] kp;
    logic signed [15:0] ki;
    logic signed [15:0] kd;
    logic               last;
  } result_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [7:0]         rx_byte_i   = 8'h00;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [1:0]         kind_o;
  logic [7:0]         tx_byte_o;
  logic [1:0]         wheel_o;
  logic signed [15:0] kp_o;
  logic signed [15:0] ki_o;
  logic signed [15:0] kd_o;
  logic               last_o;

  telemetry_frame_receiver_core #(
    .MAX_PAYLOAD_LEN(MAX_LEN)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .kind_o     (kind_o),
    .tx_byte_o  (tx_byte_o),
    .wheel_o    (wheel_o),
    .kp_o       (kp_o),
    .ki_o       (ki_o),
    .kd_o       (kd_o),
    .last_o     (last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Parser state mirrored from the block
  phase_e     rx_phase;
  logic [7:0] rx_func;
  logic [5:0] rx_left;
  logic [5:0] rx_count;
  logic [7:0] rx_sum;
  logic [7:0] rx_store [STORE_BYTES];
  result_t    pending_results [$];

  int errors      = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  bit sender_steady = 1'b0;
  int hold_req    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int seg_left    = 0;
  int stall_pct   = 0;

  function automatic void clear_parser();
    rx_phase = PH_IDLE;
    rx_func  = '0;
    rx_left  = '0;
    rx_count = '0;
    rx_sum   = '0;
    foreach (rx_store[i]) rx_store[i] = '0;
  endfunction

  // Big-endian gain word from two stored bytes
  function automatic logic [15:0] gain_word(int idx);
    return {rx_store[idx], rx_store[idx + 1]};
  endfunction

  function automatic void push_result(kind_e kind, logic [7:0] tx, logic [1:0] wheel,
                                      logic [15:0] kp, logic [15:0] ki, logic [15:0] kd);
    result_t r;
    r.kind  = kind;
    r.tx    = tx;
    r.wheel = wheel;
    r.kp    = kp;
    r.ki    = ki;
    r.kd    = kd;
    r.last  = 1'b0;
    pending_results.push_back(r);
  endfunction

  function automatic void push_triple(logic [1:0] wheel, int base);
    push_result(KIND_PID, 8'h00, wheel, gain_word(base), gain_word(base + 2),
                gain_word(base + 4));
  endfunction

  // Acknowledge frame, closed by the 8-bit sum of its first six bytes
  function automatic void push_ack(logic [7:0] func, logic [7:0] sum);
    logic [7:0] ack [ACK_LEN];
    logic [7:0] chk;
    int i;
    ack[0] = SOF_1;
    ack[1] = SOF_1;
    ack[2] = ACK_ADDR;
    ack[3] = ACK_FUNC;
    ack[4] = func;
    ack[5] = sum;
    chk = '0;
    for (i = 0; i < ACK_LEN - 1; i++) chk += ack[i];
    ack[ACK_LEN - 1] = chk;
    for (i = 0; i < ACK_LEN; i++) push_result(KIND_ACK, ack[i], 2'd0, '0, '0, '0);
  endfunction

  // Advance the mirrored parser by one accepted byte and queue what it causes
  function automatic void parse_byte(logic [7:0] b);
    int      size_prior;
    result_t r;
    size_prior = pending_results.size();
    if (rx_phase == PH_IDLE && b == SOF_1) begin
      rx_phase = PH_SOF2;
      rx_sum   = b;
    end else if (rx_phase == PH_SOF2 && b == SOF_2) begin
      rx_phase = PH_FUNC;
      rx_sum  += b;
    end else if (rx_phase == PH_FUNC && b < FUNC_LIMIT) begin
      rx_phase = PH_LEN;
      rx_func  = b;
      rx_sum  += b;
    end else if (rx_phase == PH_LEN && b <= MAX_LEN) begin
      rx_phase = PH_DATA;
      rx_left  = b[5:0];
      rx_count = '0;
      rx_sum  += b;
    end else if (rx_phase == PH_DATA && rx_left != 0) begin
      if (rx_count < STORE_BYTES) rx_store[rx_count] = b;
      rx_count++;
      rx_left--;
      rx_sum += b;
      if (rx_left == 0) rx_phase = PH_CHK;
    end else if (rx_phase == PH_CHK) begin
      rx_phase = PH_IDLE;
      // checksum byte lands in the store after a short payload
      if (rx_count < STORE_BYTES) rx_store[rx_count] = b;
      if (b == rx_sum) begin
        if (rx_func == FUNC_REQ) begin
          if (rx_store[0] == SUB_READ) push_result(KIND_READ, '0, '0, '0, '0, '0);
          else if (rx_store[0] == SUB_DEFAULT) push_result(KIND_DEFAULT, '0, '0, '0, '0, '0);
        end else if (rx_func == FUNC_PID3) begin
          push_triple(2'd0, 0);
          push_triple(2'd1, 6);
          push_triple(2'd2, 12);
          push_ack(rx_func, rx_sum);
        end else if (rx_func == FUNC_PID1) begin
          push_triple(2'd3, 0);
          push_ack(rx_func, rx_sum);
        end else if (rx_func >= FUNC_ACK_LO && rx_func <= FUNC_ACK_HI) begin
          push_ack(rx_func, rx_sum);
        end
      end
    end else begin
      rx_phase = PH_IDLE;
    end
    if (pending_results.size() > size_prior) begin
      r = pending_results.pop_back();
      r.last = 1'b1;
      pending_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // Result checker: compare every accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", kind_o));
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 16'(kind_o), 16'(want.kind));
        check_field("tx_byte", 16'(tx_byte_o), 16'(want.tx));
        check_field("wheel", 16'(wheel_o), 16'(want.wheel));
        check_field("kp", kp_o, want.kp);
        check_field("ki", ki_o, want.ki);
        check_field("kd", kd_o, want.kd);
        check_field("last", 16'(last_o), 16'(want.last));
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request
  always @(negedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(4, 60);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 25;
          2:       stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end else begin
        seg_left--;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offer one item; gaps are inserted between bursts unless the sender is steady
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (!sender_steady && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_bytes(byte_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  function automatic byte_q_t build_frame(logic [7:0] func, byte_q_t body, bit good);
    byte_q_t    f;
    logic [7:0] sum;
    f = {SOF_1, SOF_2, func, 8'(body.size())};
    foreach (body[i]) f.push_back(body[i]);
    sum = '0;
    foreach (f[i]) sum += f[i];
    f.push_back(good ? sum : 8'(sum + 8'($urandom_range(1, 255))));
    return f;
  endfunction

  task automatic send_frame(logic [7:0] func, byte_q_t body, bit good);
    send_bytes(build_frame(func, body, good));
  endtask

  // Random byte, biased towards the gain extremes
  function automatic logic [7:0] random_byte();
    logic [7:0] b;
    case ($urandom_range(0, 7))
      0:       b = 8'h00;
      1:       b = 8'hFF;
      2:       b = $urandom_range(0, 1) ? 8'h7F : 8'h80;
      default: b = 8'($urandom);
    endcase
    return b;
  endfunction

  function automatic byte_q_t random_body(int len);
    byte_q_t body;
    repeat (len) body.push_back(random_byte());
    return body;
  endfunction

  function automatic byte_q_t random_frame();
    byte_q_t    body;
    logic [7:0] func;
    int         len;
    int         sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) begin
      func = FUNC_PID3;
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_LEN) : STORE_BYTES;
    end else if (sel < 40) begin
      func = FUNC_PID1;
      len  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_LEN) : 6;
    end else if (sel < 55) begin
      func = FUNC_REQ;
      len  = $urandom_range(1, 4);
    end else if (sel < 75) begin
      func = 8'($urandom_range(FUNC_ACK_LO, FUNC_ACK_HI));
      len  = $urandom_range(1, 12);
    end else begin
      func = 8'($urandom_range(0, FUNC_LIMIT - 1));
      len  = ($urandom_range(0, 7) == 0) ? MAX_LEN : $urandom_range(1, 8);
    end
    body = random_body(len);
    if (func == FUNC_REQ && $urandom_range(0, 3) != 0)
      body[0] = $urandom_range(0, 1) ? SUB_READ : SUB_DEFAULT;
    return build_frame(func, body, $urandom_range(0, 9) != 0);
  endfunction

  // Event requests: both subcommands, an unknown one, a bad checksum
  task automatic test_request_frames();
    send_frame(FUNC_REQ, {SUB_READ}, 1'b1);
    send_frame(FUNC_REQ, {SUB_DEFAULT, 8'h00}, 1'b1);
    send_frame(FUNC_REQ, {8'h55}, 1'b1);
    send_frame(FUNC_REQ, {SUB_READ}, 1'b0);
  endtask

  // Gain triples and acknowledges, including long and short payloads
  task automatic test_gain_frames();
    byte_q_t    ramp;
    logic [7:0] f;
    send_frame(FUNC_PID3, {8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
                           8'h01, 8'hFF, 8'hFE, 8'h12, 8'h34, 8'h80, 8'h01, 8'h7F, 8'hFE},
               1'b1);
    send_frame(FUNC_PID1, {8'h7F, 8'hFF, 8'h80, 8'h00, 8'h00, 8'h00}, 1'b1);
    send_frame(FUNC_PID3, random_body(STORE_BYTES), 1'b0);
    // payload longer than the store: excess only counts in the checksum
    for (int i = 0; i < MAX_LEN; i++) ramp.push_back(8'(i * 5 + 3));
    send_frame(FUNC_PID3, ramp, 1'b1);
    // short payload: triples pick up the checksum byte and stale bytes
    send_frame(FUNC_PID1, {8'h01, 8'h02}, 1'b1);
    send_frame(FUNC_PID3, {8'hC3}, 1'b1);
    for (f = FUNC_ACK_LO; f <= FUNC_ACK_HI; f++) send_frame(f, {8'(f)}, 1'b1);
  endtask

  // Broken framing: every malformed position drops the parser back to idle
  task automatic test_framing_errors();
    byte_q_t q;
    send_bytes({SOF_1, SOF_2, FUNC_ACK_LO, 8'h00, 8'h05});
    send_bytes({SOF_1, SOF_2, FUNC_ACK_LO, 8'd50, 8'h00});
    send_bytes({SOF_1, SOF_2, FUNC_ACK_HI, 8'hFF});
    send_bytes({SOF_1, SOF_2, FUNC_LIMIT, 8'h01});
    send_frame(8'(FUNC_LIMIT - 1), {8'h00}, 1'b1);
    // repeated start byte is not taken as a new start
    q = build_frame(FUNC_ACK_LO, {8'h00}, 1'b1);
    q.push_front(SOF_1);
    send_bytes(q);
    send_bytes({SOF_1, 8'h00, 8'hFF, SOF_2});
    send_frame(FUNC_ACK_LO, {8'hFF}, 1'b1);
  endtask

  // Long receiver hold-off with the sender going flat out, to fill the job queue
  task automatic test_backpressure();
    sender_steady = 1'b1;
    hold_req++;
    repeat (2) send_frame(FUNC_PID3, random_body(STORE_BYTES), 1'b1);
    repeat (2) send_frame(FUNC_ACK_HI, {8'h00}, 1'b1);
    send_frame(FUNC_REQ, {SUB_DEFAULT}, 1'b1);
    sender_steady = 1'b0;
  endtask

  // Mostly well-formed frames with random content, plus noise and broken frames
  task automatic test_random_traffic();
    byte_q_t f;
    int      sent;
    int      k;
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3))
          send_byte($urandom_range(0, 2) == 0 ? SOF_1 : 8'($urandom));
      f = random_frame();
      if ($urandom_range(0, 11) == 0) begin
        k = $urandom_range(0, f.size() - 1);
        f[k] = 8'($urandom);
      end
      if ($urandom_range(0, 15) == 0)
        repeat ($urandom_range(1, f.size() - 1)) void'(f.pop_back());
      sent += f.size();
      send_bytes(f);
    end
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clear_parser();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_request_frames();
    test_gain_frames();
    test_framing_errors();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
